>>> rtl/ess_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ess_pkg
// Shared widths, microcode format and control program of the score sorter.
// ----------------------------------------------------------------------------
package ess_pkg;

	localparam int SCORE_W       = 16;
	localparam int POS_W         = 4;
	localparam int ENTRIES_DEF   = 16;
	localparam int KEY_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'd0,
		ST_OUTER = 3'd1,
		ST_LDI   = 3'd2,
		ST_CMP   = 3'd3,
		ST_EMIT  = 3'd4,
		ST_DONE  = 3'd5
	} step_t;

	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_OUT
	} wait_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NOT_LAST,
		C_J_END,
		C_J_MORE,
		C_I_MORE
	} cond_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_J,
		RD_JN
	} rd_sel_t;

	typedef struct packed {
		wait_t   wait_on;
		cond_t   cond;
		step_t   target;
		logic    rdy;
		rd_sel_t rd_sel;
		logic    load_entry;
		logic    set_j;
		logic    ld_ri;
		logic    cmp_swap;
		logic    inc_j;
		logic    emit;
		logic    clear;
	} ucode_t;

	typedef struct packed {
		logic    rdy;
		rd_sel_t rd_sel;
		logic    load_entry;
		logic    set_j;
		logic    ld_ri;
		logic    cmp_swap;
		logic    inc_j;
		logic    emit;
		logic    clear;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic last;
		logic out_free;
		logic j_end;
		logic j_more;
		logic i_more;
	} stat_t;

	function automatic ucode_t ucode(input step_t s);
		ucode_t u;
		u = '{wait_on: W_NONE, cond: C_NONE, target: ST_LOAD, rdy: 1'b0, rd_sel: RD_I,
			default: 1'b0};
		case (s)
			ST_LOAD: begin
				u.wait_on    = W_IN;
				u.rdy        = 1'b1;
				u.load_entry = 1'b1;
				u.cond       = C_NOT_LAST;
				u.target     = ST_LOAD;
			end
			ST_OUTER: begin
				u.rd_sel = RD_I;
				u.set_j  = 1'b1;
			end
			ST_LDI: begin
				u.ld_ri  = 1'b1;
				u.rd_sel = RD_J;
				u.cond   = C_J_END;
				u.target = ST_EMIT;
			end
			ST_CMP: begin
				u.cmp_swap = 1'b1;
				u.inc_j    = 1'b1;
				u.rd_sel   = RD_JN;
				u.cond     = C_J_MORE;
				u.target   = ST_CMP;
			end
			ST_EMIT: begin
				u.wait_on = W_OUT;
				u.emit    = 1'b1;
				u.cond    = C_I_MORE;
				u.target  = ST_OUTER;
			end
			ST_DONE: begin
				u.clear  = 1'b1;
				u.cond   = C_ALWAYS;
				u.target = ST_LOAD;
			end
			default: begin
				u.cond   = C_ALWAYS;
				u.target = ST_LOAD;
			end
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ess_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ess_if
// Valid/ready channels: record words in, sorted words out.
// ----------------------------------------------------------------------------
interface ess_rec_if import ess_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score_in;
	logic               last_in;

	modport source (output valid, output score_in, output last_in, input ready);
	modport sink   (input valid, input score_in, input last_in, output ready);
endinterface

interface ess_res_if import ess_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score_out;
	logic [POS_W-1:0]   orig_position;
	logic               last_out;

	modport source (output valid, output score_out, output orig_position, output last_out,
		input ready);
	modport sink   (input valid, input score_out, input orig_position, input last_out,
		output ready);
endinterface
`default_nettype wire

>>> rtl/ess_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ess_seq
// Microcode sequencer: step counter, control ROM, wait and jump logic.
// ----------------------------------------------------------------------------
module ess_seq import ess_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t  step_q;
	step_t  step_nxt;
	ucode_t uw;
	logic   go;
	logic   taken;

	assign uw = ucode(step_q);

	always_comb begin
		case (uw.wait_on)
			W_NONE:  go = 1'b1;
			W_IN:    go = stat.in_acc;
			W_OUT:   go = stat.out_free;
			default: go = 1'b1;
		endcase
	end

	always_comb begin
		case (uw.cond)
			C_NONE:     taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NOT_LAST: taken = !stat.last;
			C_J_END:    taken = stat.j_end;
			C_J_MORE:   taken = stat.j_more;
			C_I_MORE:   taken = stat.i_more;
			default:    taken = 1'b1;
		endcase
	end

	// next step
	always_comb begin
		if (!go) begin
			step_nxt = step_q;
		end else if (taken) begin
			step_nxt = uw.target;
		end else begin
			step_nxt = step_t'(step_q + 3'd1);
		end
	end

	// control outputs, actions fire only once the step proceeds
	always_comb begin
		ctrl.rdy        = uw.rdy;
		ctrl.rd_sel     = uw.rd_sel;
		ctrl.load_entry = uw.load_entry && go;
		ctrl.set_j      = uw.set_j && go;
		ctrl.ld_ri      = uw.ld_ri && go;
		ctrl.cmp_swap   = uw.cmp_swap && go;
		ctrl.inc_j      = uw.inc_j && go;
		ctrl.emit       = uw.emit && go;
		ctrl.clear      = uw.clear && go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/exchange_sort_scores_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exchange_sort_scores_core
// Loads a set of scores, exchange-sorts them, emits them in ascending order.
// ----------------------------------------------------------------------------
// Records load one word per cycle into a simple dual-port store, each tagged
// with its load position; words past ENTRIES are dropped. The word flagged last
// starts the sort, and no record is taken until the whole set has been sent.
// The sort makes one compare per cycle, set by the one read and one write
// port of the entry store. Sorted word i leaves as soon as its outer pass
// ends; a stalled output holds the sequencer at that point.
// ----------------------------------------------------------------------------
module exchange_sort_scores_core import ess_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	ess_rec_if.sink        records,
	ess_res_if.source      sorted
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = KEY_WIDTH + AW;

	ctrl_t ctrl;
	stat_t stat;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] j_inc;
	logic          room;

	logic [EW-1:0] mem [ENTRIES];
	logic [EW-1:0] rd_q;
	logic [EW-1:0] ri_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;
	logic          swap;

	logic [KEY_WIDTH-1:0] key_in;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [KEY_WIDTH-1:0] ri_key;

	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_last_q;

	ess_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign i_inc  = i_q + 1'b1;
	assign j_inc  = j_q + 1'b1;
	assign room   = cnt_q < CW'(ENTRIES);
	assign key_in = KEY_WIDTH'(records.score_in);
	assign rd_key = rd_q[EW-1:AW];
	assign ri_key = ri_q[EW-1:AW];
	assign swap   = rd_key < ri_key;

	assign records.ready = ctrl.rdy;

	always_comb begin
		stat.in_acc   = records.valid && ctrl.rdy;
		stat.last     = records.last_in;
		stat.out_free = !out_valid_q || sorted.ready;
		stat.j_end    = j_q >= cnt_q;
		stat.j_more   = j_inc < cnt_q;
		stat.i_more   = i_inc < cnt_q;
	end

	always_comb begin
		case (ctrl.rd_sel)
			RD_I:    rd_addr = i_q[AW-1:0];
			RD_J:    rd_addr = j_q[AW-1:0];
			RD_JN:   rd_addr = j_inc[AW-1:0];
			default: rd_addr = i_q[AW-1:0];
		endcase
	end

	// load writes at the fill point, compare writes the displaced entry back at j
	assign wr_en   = (ctrl.load_entry && room) || (ctrl.cmp_swap && swap);
	assign wr_addr = ctrl.load_entry ? cnt_q[AW-1:0] : j_q[AW-1:0];
	assign wr_data = ctrl.load_entry ? {key_in, cnt_q[AW-1:0]} : ri_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// running minimum of slot i
	always_ff @(posedge clk) begin
		if (ctrl.ld_ri || (ctrl.cmp_swap && swap)) begin
			ri_q <= rd_q;
		end
		if (ctrl.emit) begin
			out_score_q <= SCORE_W'(ri_key);
			out_pos_q   <= POS_W'(ri_q[AW-1:0]);
			out_last_q  <= !stat.i_more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				cnt_q <= '0;
			end else if (ctrl.load_entry && room) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (ctrl.clear) begin
				i_q <= '0;
			end else if (ctrl.emit) begin
				i_q <= i_inc;
			end

			if (ctrl.clear) begin
				j_q <= '0;
			end else if (ctrl.set_j) begin
				j_q <= i_inc;
			end else if (ctrl.inc_j) begin
				j_q <= j_inc;
			end

			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (sorted.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sorted.valid         = out_valid_q;
	assign sorted.score_out     = out_score_q;
	assign sorted.orig_position = out_pos_q;
	assign sorted.last_out      = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("fill count beyond store depth");

	a_idle_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rdy |-> (i_q == '0 && j_q == '0))
		else $error("sort counters not cleared while loading");

	a_cmp_index: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmp_swap |-> (j_q < cnt_q))
		else $error("compare outside loaded entries");

	a_min_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmp_swap && swap) |=> (ri_key < $past(ri_key)))
		else $error("exchange did not lower slot key");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (i_q < cnt_q && (!out_valid_q || sorted.ready)))
		else $error("emit with no free output or bad slot");

endmodule
`default_nettype wire
